// ===== rtl/dcp_pkg.sv =====
package dcp_pkg;

	// field widths
	localparam int FRAC_BITS = 16;
	localparam int TAG_W     = 16;
	localparam int POS_W     = 32;
	localparam int MASS_W    = 32;
	localparam int REST_W    = 31;
	localparam int STIFF_W   = 17;
	localparam logic [STIFF_W-1:0] STIFF_ONE = STIFF_W'(1 << 16);

	// internal widths
	localparam int DM_W    = POS_W + 1;           // |p1 - p2|
	localparam int SQ_W    = 2 * DM_W;            // one squared axis
	localparam int RAD_W   = SQ_W;                // sum of three squares
	localparam int ROOT_W  = RAD_W / 2;           // distance
	localparam int SREM_W  = ROOT_W + 2;          // square root remainder
	localparam int DEN_W   = ROOT_W + 1;          // distance plus a tenth
	localparam int WQ_W    = STIFF_W;             // mass weight quotient
	localparam int WREM_W  = MASS_W + WQ_W;       // weight dividend
	localparam int G_BITS  = 30;
	localparam int GQ_W    = G_BITS + 1;          // direction quotient
	localparam int GREM_W  = DM_W + G_BITS + 1;   // direction dividend
	localparam int T_W     = ROOT_W + 1;          // error times weight
	localparam int TL_W    = 17;                  // low slice of t
	localparam int TH_W    = T_W - TL_W;          // high slice of t
	localparam int PP_W    = TL_W + GQ_W;         // partial product
	localparam int PR_W    = T_W + GQ_W + 1;      // full product
	localparam int M_W     = T_W + 1;             // move magnitude
	localparam int SUM_W   = POS_W + 5;           // position plus move

	localparam logic [DEN_W-1:0] TENTH = DEN_W'(((1 << FRAC_BITS) + 5) / 10);

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// back pipeline stage numbers
	localparam int SQ_STEPS = ROOT_W;
	localparam int ST_SQ_END = SQ_STEPS;
	localparam int ST_E     = ST_SQ_END + 1;
	localparam int ST_F     = ST_E + 1;
	localparam int ST_G0    = ST_F + 1;
	localparam int ST_G_END = ST_G0 + GQ_W - 1;
	localparam int ST_M1    = ST_G_END + 1;
	localparam int ST_M2    = ST_M1 + 1;
	localparam int N_ST     = ST_M2 + 1;

	typedef struct packed {
		logic                         bypass;
		logic [TAG_W-1:0]             first_tag;
		logic [TAG_W-1:0]             second_tag;
		logic [2:0][POS_W-1:0]        p1;
		logic [2:0][POS_W-1:0]        p2;
		logic [MASS_W-1:0]            w1;
		logic [MASS_W-1:0]            w2;
		logic [REST_W-1:0]            rest;
		logic [2:0]                   dneg;
		logic [2:0][DM_W-1:0]         dm;
		logic [2:0][SQ_W-1:0]         sq;
	} fe_item_t;

	typedef struct packed {
		logic                         bypass;
		logic [TAG_W-1:0]             first_tag;
		logic [TAG_W-1:0]             second_tag;
		logic [2:0][POS_W-1:0]        p1;
		logic [2:0][POS_W-1:0]        p2;
		logic [REST_W-1:0]            rest;
		logic [2:0]                   dneg;
		logic [2:0][DM_W-1:0]         dm;
		logic [RAD_W-1:0]             radicand;
		logic [SREM_W-1:0]            srem;
		logic [ROOT_W-1:0]            root;
		logic [MASS_W:0]              wsum;
		logic [WREM_W-1:0]            wrem;
		logic [WQ_W-1:0]              wq;
		logic [DEN_W-1:0]             denom;
		logic                         eneg;
		logic [ROOT_W-1:0]            emag;
		logic [STIFF_W-1:0]           c1;
		logic [STIFF_W-1:0]           c2;
		logic [T_W-1:0]               t1;
		logic [T_W-1:0]               t2;
		logic [2:0][GREM_W-1:0]       grem;
		logic [2:0][GQ_W-1:0]         gq;
		logic [2:0][PP_W-1:0]         pl1;
		logic [2:0][PP_W-1:0]         ph1;
		logic [2:0][PP_W-1:0]         pl2;
		logic [2:0][PP_W-1:0]         ph2;
		logic [2:0][M_W-1:0]          m1;
		logic [2:0][M_W-1:0]          m2;
	} be_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== rtl/dcp_in_if.sv =====
interface dcp_in_if;
	logic                                valid;
	logic                                ready;
	logic [dcp_pkg::TAG_W-1:0]           first_tag;
	logic [dcp_pkg::TAG_W-1:0]           second_tag;
	logic signed [dcp_pkg::POS_W-1:0]    first_x;
	logic signed [dcp_pkg::POS_W-1:0]    first_y;
	logic signed [dcp_pkg::POS_W-1:0]    first_z;
	logic signed [dcp_pkg::POS_W-1:0]    second_x;
	logic signed [dcp_pkg::POS_W-1:0]    second_y;
	logic signed [dcp_pkg::POS_W-1:0]    second_z;
	logic [dcp_pkg::MASS_W-1:0]          first_inv_mass;
	logic [dcp_pkg::MASS_W-1:0]          second_inv_mass;
	logic [dcp_pkg::REST_W-1:0]          rest_length;

	modport source (output valid, first_tag, second_tag, first_x, first_y, first_z,
		second_x, second_y, second_z, first_inv_mass, second_inv_mass, rest_length,
		input ready);
	modport sink (input valid, first_tag, second_tag, first_x, first_y, first_z,
		second_x, second_y, second_z, first_inv_mass, second_inv_mass, rest_length,
		output ready);
endinterface

// ===== rtl/dcp_out_if.sv =====
interface dcp_out_if;
	logic                                valid;
	logic                                ready;
	logic [dcp_pkg::TAG_W-1:0]           out_first_tag;
	logic [dcp_pkg::TAG_W-1:0]           out_second_tag;
	logic signed [dcp_pkg::POS_W-1:0]    new_first_x;
	logic signed [dcp_pkg::POS_W-1:0]    new_first_y;
	logic signed [dcp_pkg::POS_W-1:0]    new_first_z;
	logic signed [dcp_pkg::POS_W-1:0]    new_second_x;
	logic signed [dcp_pkg::POS_W-1:0]    new_second_y;
	logic signed [dcp_pkg::POS_W-1:0]    new_second_z;

	modport source (output valid, out_first_tag, out_second_tag, new_first_x, new_first_y,
		new_first_z, new_second_x, new_second_y, new_second_z, input ready);
	modport sink (input valid, out_first_tag, out_second_tag, new_first_x, new_first_y,
		new_first_z, new_second_x, new_second_y, new_second_z, output ready);
endinterface

// ===== rtl/dcp_cfg_if.sv =====
interface dcp_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [dcp_pkg::STIFF_W-1:0]         data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/dcp_front.sv =====
module dcp_front (
	input  logic                clk,
	input  logic                arst_n,
	dcp_in_if.sink              item,
	output logic                push,
	output dcp_pkg::fe_item_t   push_data,
	input  dcp_pkg::q_status_t  status
);

	dcp_pkg::fe_item_t item_s1;
	dcp_pkg::fe_item_t nx;
	logic              vld_s1;
	logic              take;

	assign item.ready = !vld_s1 || !status.full;
	assign take       = item.valid && item.ready;
	assign push       = vld_s1 && !status.full;

	// classify and form the axis differences
	always_comb begin
		logic [dcp_pkg::DM_W-1:0] sd;
		nx            = '0;
		nx.first_tag  = item.first_tag;
		nx.second_tag = item.second_tag;
		nx.p1[0]      = item.first_x;
		nx.p1[1]      = item.first_y;
		nx.p1[2]      = item.first_z;
		nx.p2[0]      = item.second_x;
		nx.p2[1]      = item.second_y;
		nx.p2[2]      = item.second_z;
		nx.w1         = item.first_inv_mass;
		nx.w2         = item.second_inv_mass;
		nx.rest       = item.rest_length;
		nx.bypass     = (item.first_inv_mass == '0) && (item.second_inv_mass == '0);
		for (int c = 0; c < 3; c++) begin
			sd = {nx.p1[c][dcp_pkg::POS_W-1], nx.p1[c]} - {nx.p2[c][dcp_pkg::POS_W-1], nx.p2[c]};
			nx.dneg[c] = sd[dcp_pkg::DM_W-1];
			nx.dm[c]   = sd[dcp_pkg::DM_W-1] ? (~sd + 1'b1) : sd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= nx;
		end
	end

	// squares on the way into the queue
	always_comb begin
		push_data = item_s1;
		for (int c = 0; c < 3; c++) begin
			push_data.sq[c] = dcp_pkg::SQ_W'(item_s1.dm[c]) * dcp_pkg::SQ_W'(item_s1.dm[c]);
		end
	end

endmodule

// ===== rtl/dcp_queue.sv =====
module dcp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dcp_pkg::fe_item_t   push_data,
	input  logic                pop,
	output dcp_pkg::fe_item_t   pop_data,
	output dcp_pkg::q_status_t  status
);

	dcp_pkg::fe_item_t              mem_q [dcp_pkg::Q_DEPTH];
	logic [dcp_pkg::Q_AW-1:0]       wr_q;
	logic [dcp_pkg::Q_AW-1:0]       rd_q;
	logic [dcp_pkg::Q_CW-1:0]       cnt_q;

	assign status.full  = (cnt_q == dcp_pkg::Q_CW'(dcp_pkg::Q_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign pop_data     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/dcp_back.sv =====
module dcp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dcp_pkg::q_status_t           status,
	input  dcp_pkg::fe_item_t            pop_data,
	output logic                         pop,
	input  logic [dcp_pkg::STIFF_W-1:0]  stiffness,
	dcp_out_if.source                    result
);

	dcp_pkg::be_item_t pipe_q [dcp_pkg::N_ST];
	dcp_pkg::be_item_t nxt    [dcp_pkg::N_ST];
	logic [dcp_pkg::N_ST-1:0] vld_q;
	logic                     adv;

	logic                                res_vld_q;
	logic [1:0][dcp_pkg::TAG_W-1:0]      tag_q;
	logic [2:0][dcp_pkg::POS_W-1:0]      np1_q;
	logic [2:0][dcp_pkg::POS_W-1:0]      np2_q;
	logic [2:0][dcp_pkg::POS_W-1:0]      np1;
	logic [2:0][dcp_pkg::POS_W-1:0]      np2;

	assign adv = !res_vld_q || result.ready;
	assign pop = !status.empty && adv;

	function automatic dcp_pkg::be_item_t load_step(dcp_pkg::fe_item_t f);
		dcp_pkg::be_item_t y;
		y            = '0;
		y.bypass     = f.bypass;
		y.first_tag  = f.first_tag;
		y.second_tag = f.second_tag;
		y.p1         = f.p1;
		y.p2         = f.p2;
		y.rest       = f.rest;
		y.dneg       = f.dneg;
		y.dm         = f.dm;
		y.radicand   = f.sq[0] + f.sq[1] + f.sq[2];
		y.wsum       = (dcp_pkg::MASS_W+1)'(f.w1) + (dcp_pkg::MASS_W+1)'(f.w2);
		y.wrem       = {1'b0, f.w1, {(dcp_pkg::WQ_W-1){1'b0}}}
			+ dcp_pkg::WREM_W'(y.wsum >> 1);
		return y;
	endfunction

	// one result bit of the distance root
	function automatic dcp_pkg::be_item_t sqrt_step(dcp_pkg::be_item_t x);
		dcp_pkg::be_item_t y;
		logic [dcp_pkg::SREM_W+1:0] rs;
		logic [dcp_pkg::SREM_W+1:0] tr;
		y  = x;
		rs = {x.srem, x.radicand[dcp_pkg::RAD_W-1 -: 2]};
		tr = (dcp_pkg::SREM_W+2)'({x.root, 2'b01});
		y.radicand = {x.radicand[dcp_pkg::RAD_W-3:0], 2'b00};
		if (rs >= tr) begin
			y.srem = dcp_pkg::SREM_W'(rs - tr);
			y.root = {x.root[dcp_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			y.srem = rs[dcp_pkg::SREM_W-1:0];
			y.root = {x.root[dcp_pkg::ROOT_W-2:0], 1'b0};
		end
		return y;
	endfunction

	// one quotient bit of the mass weight
	function automatic dcp_pkg::be_item_t wdiv_step(dcp_pkg::be_item_t x, int i);
		dcp_pkg::be_item_t y;
		logic [dcp_pkg::WREM_W:0] dv;
		logic [dcp_pkg::WREM_W:0] rm;
		logic                     b;
		y  = x;
		dv = (dcp_pkg::WREM_W+1)'(x.wsum) << i;
		rm = {1'b0, x.wrem};
		b  = (rm >= dv);
		if (b) begin
			y.wrem = dcp_pkg::WREM_W'(rm - dv);
		end
		y.wq = {x.wq[dcp_pkg::WQ_W-2:0], b};
		return y;
	endfunction

	// error, denominator and per-particle gains
	function automatic dcp_pkg::be_item_t e_step(dcp_pkg::be_item_t x,
		logic [dcp_pkg::STIFF_W-1:0] k);
		dcp_pkg::be_item_t y;
		logic [dcp_pkg::STIFF_W-1:0]   kc;
		logic [dcp_pkg::WQ_W-1:0]      wt1;
		logic [dcp_pkg::WQ_W-1:0]      wt2;
		logic [2*dcp_pkg::STIFF_W-1:0] pr1;
		logic [2*dcp_pkg::STIFF_W-1:0] pr2;
		y       = x;
		y.denom = dcp_pkg::DEN_W'(x.root) + dcp_pkg::TENTH;
		if (x.root >= dcp_pkg::ROOT_W'(x.rest)) begin
			y.eneg = 1'b0;
			y.emag = x.root - dcp_pkg::ROOT_W'(x.rest);
		end else begin
			y.eneg = 1'b1;
			y.emag = dcp_pkg::ROOT_W'(x.rest) - x.root;
		end
		kc  = (k > dcp_pkg::STIFF_ONE) ? dcp_pkg::STIFF_ONE : k;
		wt1 = (x.wq > dcp_pkg::STIFF_ONE) ? dcp_pkg::STIFF_ONE : x.wq;
		wt2 = dcp_pkg::STIFF_ONE - wt1;
		pr1 = (2*dcp_pkg::STIFF_W)'(kc) * (2*dcp_pkg::STIFF_W)'(wt1);
		pr2 = (2*dcp_pkg::STIFF_W)'(kc) * (2*dcp_pkg::STIFF_W)'(wt2);
		y.c1 = dcp_pkg::STIFF_W'((pr1 + (2*dcp_pkg::STIFF_W)'(32768)) >> 16);
		y.c2 = dcp_pkg::STIFF_W'((pr2 + (2*dcp_pkg::STIFF_W)'(32768)) >> 16);
		return y;
	endfunction

	// scaled error and direction dividends
	function automatic dcp_pkg::be_item_t f_step(dcp_pkg::be_item_t x);
		dcp_pkg::be_item_t y;
		logic [dcp_pkg::ROOT_W+dcp_pkg::STIFF_W-1:0] e1;
		logic [dcp_pkg::ROOT_W+dcp_pkg::STIFF_W-1:0] e2;
		y  = x;
		e1 = (dcp_pkg::ROOT_W+dcp_pkg::STIFF_W)'(x.emag)
			* (dcp_pkg::ROOT_W+dcp_pkg::STIFF_W)'(x.c1);
		e2 = (dcp_pkg::ROOT_W+dcp_pkg::STIFF_W)'(x.emag)
			* (dcp_pkg::ROOT_W+dcp_pkg::STIFF_W)'(x.c2);
		y.t1 = dcp_pkg::T_W'((e1 + (dcp_pkg::ROOT_W+dcp_pkg::STIFF_W)'(32768)) >> 16);
		y.t2 = dcp_pkg::T_W'((e2 + (dcp_pkg::ROOT_W+dcp_pkg::STIFF_W)'(32768)) >> 16);
		for (int c = 0; c < 3; c++) begin
			y.grem[c] = dcp_pkg::GREM_W'({x.dm[c], {dcp_pkg::G_BITS{1'b0}}})
				+ dcp_pkg::GREM_W'(x.denom >> 1);
			y.gq[c]   = '0;
		end
		return y;
	endfunction

	// one quotient bit of each direction component
	function automatic dcp_pkg::be_item_t gdiv_step(dcp_pkg::be_item_t x, int i);
		dcp_pkg::be_item_t y;
		logic [dcp_pkg::GREM_W:0] dv;
		logic [dcp_pkg::GREM_W:0] rm;
		logic                     b;
		y  = x;
		dv = (dcp_pkg::GREM_W+1)'(x.denom) << i;
		for (int c = 0; c < 3; c++) begin
			rm = {1'b0, x.grem[c]};
			b  = (rm >= dv);
			if (b) begin
				y.grem[c] = dcp_pkg::GREM_W'(rm - dv);
			end
			y.gq[c] = {x.gq[c][dcp_pkg::GQ_W-2:0], b};
		end
		return y;
	endfunction

	function automatic dcp_pkg::be_item_t m1_step(dcp_pkg::be_item_t x);
		dcp_pkg::be_item_t y;
		y = x;
		for (int c = 0; c < 3; c++) begin
			y.pl1[c] = dcp_pkg::PP_W'(x.t1[dcp_pkg::TL_W-1:0]) * dcp_pkg::PP_W'(x.gq[c]);
			y.ph1[c] = dcp_pkg::PP_W'(x.t1[dcp_pkg::T_W-1:dcp_pkg::TL_W])
				* dcp_pkg::PP_W'(x.gq[c]);
			y.pl2[c] = dcp_pkg::PP_W'(x.t2[dcp_pkg::TL_W-1:0]) * dcp_pkg::PP_W'(x.gq[c]);
			y.ph2[c] = dcp_pkg::PP_W'(x.t2[dcp_pkg::T_W-1:dcp_pkg::TL_W])
				* dcp_pkg::PP_W'(x.gq[c]);
		end
		return y;
	endfunction

	function automatic logic [dcp_pkg::M_W-1:0] round_move(logic [dcp_pkg::PP_W-1:0] pl,
		logic [dcp_pkg::PP_W-1:0] ph);
		logic [dcp_pkg::PR_W-1:0] pr;
		pr = dcp_pkg::PR_W'(pl) + (dcp_pkg::PR_W'(ph) << dcp_pkg::TL_W)
			+ (dcp_pkg::PR_W'(1) << (dcp_pkg::G_BITS - 1));
		return dcp_pkg::M_W'(pr >> dcp_pkg::G_BITS);
	endfunction

	function automatic dcp_pkg::be_item_t m2_step(dcp_pkg::be_item_t x);
		dcp_pkg::be_item_t y;
		y = x;
		for (int c = 0; c < 3; c++) begin
			y.m1[c] = round_move(x.pl1[c], x.ph1[c]);
			y.m2[c] = round_move(x.pl2[c], x.ph2[c]);
		end
		return y;
	endfunction

	function automatic logic [dcp_pkg::POS_W-1:0] sat_pos(logic [dcp_pkg::SUM_W-1:0] r);
		logic [dcp_pkg::SUM_W-dcp_pkg::POS_W:0] hi;
		hi = r[dcp_pkg::SUM_W-1:dcp_pkg::POS_W-1];
		if (hi == '0 || hi == '1) begin
			return r[dcp_pkg::POS_W-1:0];
		end else if (r[dcp_pkg::SUM_W-1]) begin
			return {1'b1, {(dcp_pkg::POS_W-1){1'b0}}};
		end else begin
			return {1'b0, {(dcp_pkg::POS_W-1){1'b1}}};
		end
	endfunction

	function automatic logic [dcp_pkg::POS_W-1:0] apply_move(logic [dcp_pkg::POS_W-1:0] p,
		logic [dcp_pkg::M_W-1:0] m, logic sub);
		logic [dcp_pkg::SUM_W-1:0] ps;
		logic [dcp_pkg::SUM_W-1:0] ms;
		ps = {{(dcp_pkg::SUM_W-dcp_pkg::POS_W){p[dcp_pkg::POS_W-1]}}, p};
		ms = dcp_pkg::SUM_W'(m);
		return sat_pos(sub ? (ps - ms) : (ps + ms));
	endfunction

	always_comb begin
		nxt[0] = load_step(pop_data);
		for (int s = 1; s <= dcp_pkg::ST_SQ_END; s++) begin
			nxt[s] = sqrt_step(pipe_q[s-1]);
			if (s <= dcp_pkg::WQ_W) begin
				nxt[s] = wdiv_step(nxt[s], dcp_pkg::WQ_W - s);
			end
		end
		nxt[dcp_pkg::ST_E] = e_step(pipe_q[dcp_pkg::ST_E-1], stiffness);
		nxt[dcp_pkg::ST_F] = f_step(pipe_q[dcp_pkg::ST_F-1]);
		for (int j = 0; j < dcp_pkg::GQ_W; j++) begin
			nxt[dcp_pkg::ST_G0+j] = gdiv_step(pipe_q[dcp_pkg::ST_G0+j-1], dcp_pkg::GQ_W - 1 - j);
		end
		nxt[dcp_pkg::ST_M1] = m1_step(pipe_q[dcp_pkg::ST_M1-1]);
		nxt[dcp_pkg::ST_M2] = m2_step(pipe_q[dcp_pkg::ST_M2-1]);
	end

	// corrected positions from the last stage
	always_comb begin
		logic pos;
		for (int c = 0; c < 3; c++) begin
			pos = (pipe_q[dcp_pkg::ST_M2].dneg[c] == pipe_q[dcp_pkg::ST_M2].eneg);
			if (pipe_q[dcp_pkg::ST_M2].bypass) begin
				np1[c] = pipe_q[dcp_pkg::ST_M2].p1[c];
				np2[c] = pipe_q[dcp_pkg::ST_M2].p2[c];
			end else begin
				np1[c] = apply_move(pipe_q[dcp_pkg::ST_M2].p1[c], pipe_q[dcp_pkg::ST_M2].m1[c], pos);
				np2[c] = apply_move(pipe_q[dcp_pkg::ST_M2].p2[c], pipe_q[dcp_pkg::ST_M2].m2[c], !pos);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[dcp_pkg::N_ST-2:0], pop};
			res_vld_q <= vld_q[dcp_pkg::N_ST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_q   <= nxt;
			tag_q[0] <= pipe_q[dcp_pkg::ST_M2].first_tag;
			tag_q[1] <= pipe_q[dcp_pkg::ST_M2].second_tag;
			np1_q    <= np1;
			np2_q    <= np2;
		end
	end

	assign result.valid          = res_vld_q;
	assign result.out_first_tag  = tag_q[0];
	assign result.out_second_tag = tag_q[1];
	assign result.new_first_x    = np1_q[0];
	assign result.new_first_y    = np1_q[1];
	assign result.new_first_z    = np1_q[2];
	assign result.new_second_x   = np2_q[0];
	assign result.new_second_y   = np2_q[1];
	assign result.new_second_z   = np2_q[2];

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[dcp_pkg::WQ_W] && !pipe_q[dcp_pkg::WQ_W].bypass
		|-> pipe_q[dcp_pkg::WQ_W].wq <= dcp_pkg::STIFF_ONE)
		else $error("mass weight above one");

	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[dcp_pkg::ST_SQ_END]
		|-> pipe_q[dcp_pkg::ST_SQ_END].srem <= {pipe_q[dcp_pkg::ST_SQ_END].root, 1'b0})
		else $error("root remainder out of range");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[dcp_pkg::ST_G_END]
		|-> pipe_q[dcp_pkg::ST_G_END].gq[0] <= (dcp_pkg::GQ_W'(1) << dcp_pkg::G_BITS)
		&& pipe_q[dcp_pkg::ST_G_END].gq[1] <= (dcp_pkg::GQ_W'(1) << dcp_pkg::G_BITS)
		&& pipe_q[dcp_pkg::ST_G_END].gq[2] <= (dcp_pkg::GQ_W'(1) << dcp_pkg::G_BITS))
		else $error("direction component above one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q) && $stable(res_vld_q))
		else $error("pipeline moved during stall");

endmodule

// ===== rtl/distance_constraint_projection_top.sv =====
// distance constraint projection, one constraint word in, one corrected word out
//
// item   : two Q16.16 particle positions, their inverse masses, rest length and
//          two tags; a word is taken when valid and ready are both high
// result : both corrected positions, saturated to 32 bits, with the tags copied
// cfg    : write-only port for the per-iteration stiffness (Q1.16, 65536 is one);
//          always ready, to be written only while no word is in flight
//
// throughput is one word per cycle while result is not stalled; the back
// pipeline holds the 33-step square root and the 31-step direction
// divider, behind the front register and the queue
// reset clears all valid flags and the queue, and sets the stiffness to one
// when result is stalled the back pipeline freezes; the four-entry queue and
// the front register keep taking words until the queue fills, then item.ready
// drops; the result word holds until it is taken
module distance_constraint_projection_top (
	input  logic       clk,
	input  logic       arst_n,
	dcp_in_if.sink     item,
	dcp_out_if.source  result,
	dcp_cfg_if.sink    cfg
);

	// stiffness register
	logic [dcp_pkg::STIFF_W-1:0] stiff_q;

	// front to queue
	logic              push;
	dcp_pkg::fe_item_t push_data;

	// queue to back
	logic               pop;
	dcp_pkg::fe_item_t  pop_data;
	dcp_pkg::q_status_t q_status;

	// config writes are never refused
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= dcp_pkg::STIFF_ONE;
		end else if (cfg.valid && cfg.ready) begin
			stiff_q <= cfg.data;
		end
	end

	// accept, difference and squares, bypass flag for two fixed particles
	dcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.push      (push),
		.push_data (push_data),
		.status    (q_status)
	);

	// decouples the front from back pipeline stalls
	dcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	// root, weights, direction divide, moves and output register
	dcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (q_status),
		.pop_data  (pop_data),
		.pop       (pop),
		.stiffness (stiff_q),
		.result    (result)
	);

endmodule
